// File: rtl/dsfi_pkg.sv
package dsfi_pkg;

  // Marker letters that open every message in a storage file.
  localparam logic [7:0] MARK_D   = 8'h44;
  localparam logic [7:0] MARK_L   = 8'h4C;
  localparam logic [7:0] MARK_T   = 8'h54;
  localparam logic [7:0] MARK_END = 8'h01;

  // Header byte counts at which the big-endian length bytes arrive.
  localparam logic [4:0] LEN_HI_COUNT = 5'd16;
  localparam logic [4:0] LEN_LO_COUNT = 5'd17;

  localparam logic [15:0] LEN_ADD      = 16'd16;
  localparam int unsigned MARK_SPAN    = 3;
  localparam int unsigned RESTART_SKIP = 5;

  // Configuration register indexes.
  localparam logic [1:0] REG_STREAM_LENGTH = 2'd0;
  localparam logic [1:0] REG_START_OFFSET  = 2'd1;

  typedef enum logic [1:0] {
    EV_ENTRY = 2'd0,
    EV_SEEK  = 2'd1,
    EV_FINAL = 2'd2
  } dsfi_event_t;

  // Marker and header progress, the narrow part of the scan state.
  typedef struct packed {
    logic [1:0] marker_progress;
    logic [4:0] header_count;
    logic [7:0] length_high;
    logic       finished;
  } dsfi_ctl_t;

endpackage

// File: rtl/dsfi_step.sv
module dsfi_step #(
  parameter int OFFSET_BITS = 32
) (
  input  logic [7:0]             data_byte,
  input  dsfi_pkg::dsfi_ctl_t    ctl,
  input  logic [OFFSET_BITS-1:0] byte_position,
  input  logic [OFFSET_BITS-1:0] current_start,
  input  logic [OFFSET_BITS-1:0] expected_start,
  input  logic [31:0]            stream_length,
  output dsfi_pkg::dsfi_ctl_t    ctl_nxt,
  output logic [OFFSET_BITS-1:0] byte_position_nxt,
  output logic [OFFSET_BITS-1:0] current_start_nxt,
  output logic [OFFSET_BITS-1:0] expected_start_nxt,
  output logic                   emit,
  output dsfi_pkg::dsfi_event_t  event_kind,
  output logic [31:0]            offset
);
  import dsfi_pkg::*;

  localparam int CW = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

  logic [4:0]             hc_inc;
  logic [15:0]            msg_len;
  logic [OFFSET_BITS-1:0] next_exp;
  logic [OFFSET_BITS-1:0] mstart;
  logic [OFFSET_BITS-1:0] restart;
  logic [OFFSET_BITS-1:0] off_pos;
  logic [CW-1:0]          off_wide;

  always_comb begin
    hc_inc   = ctl.header_count + 5'd1;
    msg_len  = {ctl.length_high, data_byte} + LEN_ADD;
    next_exp = current_start + OFFSET_BITS'(msg_len);
    mstart   = byte_position - OFFSET_BITS'(MARK_SPAN);
    restart  = current_start + OFFSET_BITS'(RESTART_SKIP);
  end

  always_comb begin
    ctl_nxt            = ctl;
    byte_position_nxt  = byte_position;
    current_start_nxt  = current_start;
    expected_start_nxt = expected_start;
    emit               = 1'b0;
    event_kind         = EV_ENTRY;
    off_pos            = current_start;

    if (!ctl.finished) begin
      byte_position_nxt = byte_position + OFFSET_BITS'(1);
      if (ctl.header_count != 5'd0) begin
        ctl_nxt.header_count = hc_inc;
        if (hc_inc == LEN_HI_COUNT) begin
          ctl_nxt.length_high = data_byte;
        end else if (hc_inc == LEN_LO_COUNT) begin
          ctl_nxt.header_count = 5'd0;
          expected_start_nxt   = next_exp;
          if (CW'(next_exp) == CW'(stream_length)) begin
            ctl_nxt.finished = 1'b1;
            emit             = 1'b1;
            event_kind       = EV_FINAL;
          end
        end
      end else if (data_byte == MARK_D) begin
        ctl_nxt.marker_progress = 2'd1;
      end else if (ctl.marker_progress == 2'd1 && data_byte == MARK_L) begin
        ctl_nxt.marker_progress = 2'd2;
      end else if (ctl.marker_progress == 2'd2 && data_byte == MARK_T) begin
        ctl_nxt.marker_progress = 2'd3;
      end else if (ctl.marker_progress == 2'd3 && data_byte == MARK_END) begin
        ctl_nxt.marker_progress = 2'd0;
        if (expected_start == '0) begin
          current_start_nxt    = mstart;
          ctl_nxt.header_count = 5'd1;
        end else if (expected_start == mstart) begin
          emit                 = 1'b1;
          event_kind           = EV_ENTRY;
          current_start_nxt    = mstart;
          ctl_nxt.header_count = 5'd1;
        end else if (expected_start < mstart) begin
          // Marker past the expected start: ask the source to rewind.
          emit               = 1'b1;
          event_kind         = EV_SEEK;
          off_pos            = restart;
          byte_position_nxt  = restart;
          expected_start_nxt = '0;
        end
      end else begin
        ctl_nxt.marker_progress = 2'd0;
      end
    end

    off_wide = CW'(off_pos);
    offset   = off_wide[31:0];
  end

endmodule

// File: rtl/dlt_storage_frame_indexer.sv
// Storage-file message indexer. The block takes one byte of a log file per
// input item and keeps its byte position, starting at start_offset. It hunts
// for the message marker D,L,T,0x01, reads the big-endian length at marker
// offsets 18 and 19 and predicts the next message start as length plus 16
// (wrapped to 16 bits) past the current start. A marker at the predicted
// start produces a start entry (tuser 0) for the previous message; a marker
// past it produces a seek item (tuser 1) whose offset is the position of the
// next byte the source must send; a message that ends exactly at
// stream_length produces a final entry (tuser 2), after which bytes are
// accepted and dropped until reset. Each byte is registered, then a single
// pass of compares and adds updates the scan state and loads the result
// register, so a byte may enter in every cycle while the result side keeps
// up. Configuration writes are taken at any time but must only be made
// while no byte is in flight; writing start_offset also sets the current
// byte position.
module dlt_storage_frame_indexer #(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] data_byte

  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,   // [31:0] offset
  output logic [1:0]  out_tuser,   // [1:0] event_kind

  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import dsfi_pkg::*;

  // Input register.
  logic       in_vld_r;
  logic [7:0] in_byte_r;

  // Scan state.
  dsfi_ctl_t              ctl_r, ctl_nxt;
  logic [OFFSET_BITS-1:0] pos_r, pos_nxt;
  logic [OFFSET_BITS-1:0] cur_r, cur_nxt;
  logic [OFFSET_BITS-1:0] exp_r, exp_nxt;
  logic [31:0]            stream_length_r;

  // Result register.
  logic        out_vld_r;
  logic [31:0] out_off_r;
  dsfi_event_t out_kind_r;

  logic        emit;
  dsfi_event_t step_kind;
  logic [31:0] step_off;
  logic        advance;
  logic        cfg_we;

  // The registered byte moves on whenever the result register is free or
  // is being emptied in this cycle.
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  dsfi_step #(
    .OFFSET_BITS(OFFSET_BITS)
  ) u_step (
    .data_byte          (in_byte_r),
    .ctl                (ctl_r),
    .byte_position      (pos_r),
    .current_start      (cur_r),
    .expected_start     (exp_r),
    .stream_length      (stream_length_r),
    .ctl_nxt            (ctl_nxt),
    .byte_position_nxt  (pos_nxt),
    .current_start_nxt  (cur_nxt),
    .expected_start_nxt (exp_nxt),
    .emit               (emit),
    .event_kind         (step_kind),
    .offset             (step_off)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r <= in_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r           <= '0;
      pos_r           <= '0;
      cur_r           <= '0;
      exp_r           <= '0;
      stream_length_r <= '0;
    end else begin
      if (advance) begin
        ctl_r <= ctl_nxt;
        pos_r <= pos_nxt;
        cur_r <= cur_nxt;
        exp_r <= exp_nxt;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_STREAM_LENGTH: stream_length_r <= cfg_data;
          REG_START_OFFSET:  pos_r           <= OFFSET_BITS'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= emit;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      out_off_r  <= step_off;
      out_kind_r <= step_kind;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_off_r;
  assign out_tuser  = out_kind_r;

endmodule

// File: rtl/dsfi_checker.sv
module dsfi_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [7:0]  in_tdata,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [1:0]  cfg_index,
  input logic [31:0] cfg_data
);
  import dsfi_pkg::*;

  // A stalled result item holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result item changed while stalled");

  // The input side only stalls behind a stalled result.
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && !out_tready)
    else $error("input stalled without result back-pressure");

  // Once the final entry leaves, no further item follows.
  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && out_tuser == EV_FINAL |=> !out_tvalid)
    else $error("result item after final entry");

  // Reset leaves the block empty and ready.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid && in_tready && cfg_ready)
    else $error("block not empty after reset");

endmodule

bind dlt_storage_frame_indexer dsfi_checker u_dsfi_checker (.*);

// File: sim/dlt_storage_frame_indexer_tb.sv
module dlt_storage_frame_indexer_tb;
  import dsfi_pkg::*;

  // One index event as the block reports it: the kind travels on tuser and
  // the position on tdata.
  typedef struct packed {
    dsfi_event_t kind;
    logic [31:0] offset;
  } index_event_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;

  dlt_storage_frame_indexer DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Scanner state as the testbench expects it to be inside the block. It is
  // advanced once for every byte item that the block accepts.
  logic [31:0] scan_stream_len = '0;
  logic [31:0] scan_pos        = '0;
  logic [1:0]  scan_marker     = '0;
  logic [4:0]  scan_hdr        = '0;
  logic [7:0]  scan_len_hi     = '0;
  logic [31:0] scan_cur_start  = '0;
  logic [31:0] scan_exp_start  = '0;
  bit          scan_done       = 1'b0;

  // Index events still owed by the block, oldest first.
  index_event_t index_events[$];

  int unsigned bytes_fed      = 0;
  int unsigned events_due     = 0;
  int unsigned mismatches     = 0;
  int unsigned send_idle_pct  = 13;
  int unsigned recv_stall_pct = 57;

  // When set, the next length field is chosen so that the message ends
  // exactly at stream_length and the block closes the index.
  bit aim_last_entry = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Generous upper bound on the whole run; a hang anywhere ends up here.
  initial begin
    #2_000_000;
    $display("dlt_storage_frame_indexer_tb failed");
    $finish;
  end

  // The receiver stalls at random; a new decision is made at every falling
  // edge so that stalls land on every phase of the block's work.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      out_tready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Every accepted result is matched against the oldest owed event.
  always @(posedge clk) begin : check_results
    index_event_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (index_events.size() == 0) begin
        $error("unexpected result: event_kind %0d offset %h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        due = index_events.pop_front();
        if (out_tuser !== due.kind) begin
          $error("event_kind mismatch: expected %0d, actual %0d", due.kind, out_tuser);
          mismatches++;
        end
        if (out_tdata !== due.offset) begin
          $error("offset mismatch: expected %h, actual %h", due.offset, out_tdata);
          mismatches++;
        end
      end
    end
  end

  task automatic post_event(input dsfi_event_t kind, input logic [31:0] offset);
    index_event_t ev;
    ev.kind      = kind;
    ev.offset    = offset;
    index_events = {index_events, ev};
    events_due++;
  endtask

  // Advances the expected scanner state by one byte and records the event
  // that the byte causes, if any.
  task automatic index_byte(input logic [7:0] value);
    logic [31:0] here;
    logic [31:0] mstart;
    logic [15:0] span;
    here = scan_pos;
    // Once the last message has been indexed, the block drops every byte.
    if (scan_done) return;
    scan_pos = here + 32'd1;
    if (scan_hdr != 5'd0) begin
      // Header bytes are only counted; marker letters inside them are
      // not looked at.
      scan_hdr = scan_hdr + 5'd1;
      if (scan_hdr == LEN_HI_COUNT) begin
        scan_len_hi = value;
      end else if (scan_hdr == LEN_LO_COUNT) begin
        span = {scan_len_hi, value} + LEN_ADD;
        scan_hdr = 5'd0;
        scan_exp_start = scan_cur_start + {16'd0, span};
        if (scan_exp_start == scan_stream_len) begin
          scan_done = 1'b1;
          post_event(EV_FINAL, scan_cur_start);
        end
      end
      return;
    end
    if (value == MARK_D) begin
      scan_marker = 2'd1;
    end else if (scan_marker == 2'd1 && value == MARK_L) begin
      scan_marker = 2'd2;
    end else if (scan_marker == 2'd2 && value == MARK_T) begin
      scan_marker = 2'd3;
    end else if (scan_marker == 2'd3 && value == MARK_END) begin
      mstart = here - MARK_SPAN;
      if (scan_exp_start == 32'd0) begin
        scan_cur_start = mstart;
        scan_hdr = 5'd1;
      end else if (scan_exp_start == mstart) begin
        post_event(EV_ENTRY, scan_cur_start);
        scan_cur_start = mstart;
        scan_hdr = 5'd1;
      end else if (scan_exp_start > mstart) begin
        // A marker inside the current message is payload, not a start.
      end else begin
        // The expected start was skipped: the source has to go back.
        post_event(EV_SEEK, scan_cur_start + RESTART_SKIP);
        scan_pos = scan_cur_start + RESTART_SKIP;
        scan_exp_start = 32'd0;
      end
      scan_marker = 2'd0;
    end else begin
      scan_marker = 2'd0;
    end
  endtask

  // Sends one byte item. Called and returning at a falling edge; tvalid is
  // left high so that back-to-back items need no gap.
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = value;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    index_byte(value);
    bytes_fed++;
    @(negedge clk);
  endtask

  // Waits until every owed event has come back, then lets the pipeline
  // settle for bytes that produce nothing.
  task automatic wait_for_results(input int unsigned settle);
    in_tvalid = 1'b0;
    while (index_events.size() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_STREAM_LENGTH) begin
      scan_stream_len = value;
    end else if (idx == REG_START_OFFSET) begin
      scan_pos = value;
    end
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Length field for a new message. Most messages are short; some have a
  // length below the header size or one that wraps the 16-bit sum, both of
  // which make the following marker arrive late.
  function automatic logic [15:0] pick_length();
    logic [15:0] len_field;
    logic [15:0] span;
    int unsigned r;
    r = $urandom_range(99);
    if (aim_last_entry) begin
      span = scan_stream_len[15:0] - scan_cur_start[15:0];
      return span - LEN_ADD;
    end
    if (r < 72) len_field = 16'($urandom_range(16, 4));
    else if (r < 84) len_field = 16'($urandom_range(200, 17));
    else if (r < 92) len_field = 16'($urandom_range(3, 0));
    else len_field = 16'($urandom_range(16'hFFFF, 16'hFFF0));
    // Keep the index open: a message must not end on stream_length by chance.
    span = len_field + LEN_ADD;
    if (scan_cur_start + {16'd0, span} == scan_stream_len) len_field = len_field + 16'd1;
    return len_field;
  endfunction

  task automatic send_marker();
    send_byte(MARK_D);
    send_byte(MARK_L);
    send_byte(MARK_T);
    send_byte(MARK_END);
  endtask

  // Finishes a header that the block is in, if any. A negative forced_len
  // lets pick_length decide; letter_fill fills the header with marker letters.
  task automatic send_header(input bit letter_fill, input int forced_len);
    logic [15:0] len_field;
    logic [7:0]  fill;
    while (scan_hdr != 5'd0) begin
      if (scan_hdr == LEN_HI_COUNT - 5'd1) begin
        len_field = (forced_len >= 0) ? 16'(forced_len) : pick_length();
        send_byte(len_field[15:8]);
        send_byte(len_field[7:0]);
      end else begin
        case (scan_hdr[1:0])
          2'd0: fill = MARK_D;
          2'd1: fill = MARK_L;
          2'd2: fill = MARK_T;
          default: fill = MARK_END;
        endcase
        send_byte(letter_fill ? fill : 8'($urandom_range(255)));
      end
    end
  endtask

  // Payload filler that can never build a marker on its own.
  task automatic send_pad(input int unsigned count);
    logic [7:0] value;
    repeat (count) begin
      value = 8'($urandom_range(255));
      if (value == MARK_D || value == MARK_L) value = 8'h00;
      send_byte(value);
    end
  endtask

  // One piece of traffic: mostly a message placed at, after or before the
  // expected start, sometimes raw noise or a marker that breaks off.
  task automatic send_unit();
    int unsigned r;
    int unsigned gap;
    int unsigned n;
    logic [31:0] ahead;
    logic [7:0]  breaker;
    r = $urandom_range(99);
    if (r < 8) begin
      n = $urandom_range(12, 1);
      repeat (n) send_byte(8'($urandom_range(255)));
      send_header(1'b0, -1);
    end else if (r < 13) begin
      n = $urandom_range(3, 1);
      send_byte(MARK_D);
      if (n >= 2) send_byte(MARK_L);
      if (n >= 3) send_byte(MARK_T);
      breaker = 8'($urandom_range(255));
      if (breaker == MARK_END) breaker = 8'h00;
      send_byte(breaker);
      send_header(1'b0, -1);
    end else begin
      if (scan_exp_start != 32'd0 && scan_exp_start >= scan_pos &&
          scan_exp_start - scan_pos < 32'd400) begin
        ahead = scan_exp_start - scan_pos;
        r = $urandom_range(99);
        if (r < 80) gap = ahead;
        else if (r < 90) gap = ahead + $urandom_range(8, 1);
        else gap = ahead - $urandom_range((ahead < 8) ? ahead : 8, 0);
      end else begin
        gap = $urandom_range(6, 0);
      end
      send_pad(gap);
      send_marker();
      send_header(1'b0, -1);
    end
  endtask

  // Forces a late marker so that no expected start is pending. This keeps a
  // later jump of start_offset from leaving the scanner stuck far behind.
  task automatic clear_expected_start();
    int tries;
    send_header(1'b0, -1);
    for (tries = 0; tries < 8 && scan_exp_start != 32'd0; tries++) begin
      if (scan_exp_start >= scan_pos) begin
        if (scan_exp_start - scan_pos < 32'd400) begin
          send_pad(scan_exp_start - scan_pos + 1);
        end else begin
          wait_for_results(8);
          write_reg(REG_START_OFFSET, scan_exp_start + 32'd1);
        end
      end
      send_marker();
      send_header(1'b0, -1);
    end
  endtask

  task automatic start_phase(input logic [31:0] stream_len, input logic [31:0] start_off,
                             input int unsigned idle_pct, input int unsigned stall_pct);
    clear_expected_start();
    wait_for_results(8);
    write_reg(REG_STREAM_LENGTH, stream_len);
    write_reg(REG_START_OFFSET, start_off);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
  endtask

  task automatic run_random_traffic(input int unsigned n_bytes, input int unsigned n_events,
                                    input bit pause_midway);
    int unsigned b0;
    int unsigned e0;
    bit paused;
    b0 = bytes_fed;
    e0 = events_due;
    paused = 1'b0;
    while (bytes_fed - b0 < n_bytes || events_due - e0 < n_events) begin
      // Hold the source back once until the result side has fully drained.
      if (pause_midway && !paused && bytes_fed - b0 >= n_bytes / 2) begin
        paused = 1'b1;
        wait_for_results(0);
      end
      send_unit();
    end
  endtask

  // Field extremes, a fresh start with no expectation, an entry, a marker
  // inside a message, a late marker with its seek, broken markers and a
  // header full of marker letters.
  task automatic test_marker_handling();
    write_reg(REG_STREAM_LENGTH, 32'd0);
    write_reg(REG_START_OFFSET, 32'd0);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_marker();
    send_header(1'b1, 4);
    send_marker();
    send_header(1'b0, 8);
    // This marker falls inside the message that started just before.
    send_marker();
    send_marker();
    send_header(1'b0, 0);
    // The length above ends inside the header, so this marker is late.
    send_marker();
    send_byte(MARK_D);
    send_byte(MARK_L);
    send_byte(8'h00);
    send_byte(MARK_D);
    send_byte(MARK_L);
    send_byte(MARK_T);
    send_byte(8'h02);
    send_marker();
    send_header(1'b0, 16'hFFFF);
    send_marker();
  endtask

  // Positions around the 32-bit wrap: a marker that starts before zero and
  // ends after it, and an expected start that wraps to exactly zero, which
  // reads as no expectation at all.
  task automatic test_position_wrap();
    start_phase(32'h8000_0000, 32'hFFFF_FFFE, 57, 13);
    send_marker();
    send_header(1'b0, 16'hFFF2);
    send_pad(2);
    send_marker();
    send_header(1'b0, 4);
    send_marker();
    send_header(1'b0, -1);
    run_random_traffic(100, 5, 1'b0);
  endtask

  // A message that ends on stream_length closes the index; every byte after
  // it, markers included, is dropped.
  task automatic test_last_entry();
    clear_expected_start();
    wait_for_results(8);
    write_reg(REG_STREAM_LENGTH, 32'd0);
    write_reg(REG_START_OFFSET, 32'hFFFF_FFD8);
    aim_last_entry = 1'b1;
    send_marker();
    send_header(1'b0, -1);
    repeat (12) send_byte(8'($urandom_range(255)));
    send_marker();
  endtask

  initial begin
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    cfg_valid = 1'b0;
    cfg_index = REG_STREAM_LENGTH;
    cfg_data  = 32'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_marker_handling();

    start_phase(32'hFFFF_FFFF, 32'h0000_1000, 13, 57);
    run_random_traffic(250, 12, 1'b1);

    start_phase(32'h8000_0000, $urandom_range(32'h7000_0000, 32'h0100_0000), 57, 13);
    run_random_traffic(250, 12, 1'b0);

    test_position_wrap();

    start_phase($urandom, 32'hFFFF_FFFF, 0, 0);
    run_random_traffic(250, 12, 1'b0);

    test_last_entry();

    wait_for_results(8);
    if (mismatches == 0) begin
      $display("dlt_storage_frame_indexer_tb passed");
    end else begin
      $display("dlt_storage_frame_indexer_tb failed");
    end
    $finish;
  end

endmodule
